### hw/rtl/trs_pkg.sv
// ---------------------------------------------------------------------------
// trs_pkg
// Shared types and codes for the TCP receive session block.
// ---------------------------------------------------------------------------
package trs_pkg;

    localparam int CHAIN_LIMIT = 9;

    localparam logic [0:0] CFG_RECV_WIN = 1'd0;
    localparam logic [0:0] CFG_INIT_SEQ = 1'd1;

    localparam logic [1:0] REQ_SEG   = 2'd0;
    localparam logic [1:0] REQ_SEND  = 2'd1;
    localparam logic [1:0] REQ_CLOSE = 2'd2;

    localparam logic [1:0] ACT_OK  = 2'd0;
    localparam logic [1:0] ACT_RST = 2'd1;
    localparam logic [1:0] ACT_FIN = 2'd2;
    localparam logic [1:0] ACT_BAD = 2'd3;

    localparam logic [2:0] ST_LISTEN      = 3'd0;
    localparam logic [2:0] ST_SYN_RCVD    = 3'd1;
    localparam logic [2:0] ST_ESTABLISHED = 3'd2;
    localparam logic [2:0] ST_FIN_WAIT_1  = 3'd3;
    localparam logic [2:0] ST_CLOSE_WAIT  = 3'd4;
    localparam logic [2:0] ST_LAST_ACK    = 3'd5;
    localparam logic [2:0] ST_CLOSED      = 3'd6;
    localparam logic [2:0] ST_TIME_WAIT   = 3'd7;

    localparam logic [2:0] RK_NONE      = 3'd0;
    localparam logic [2:0] RK_ACK       = 3'd1;
    localparam logic [2:0] RK_CHALLENGE = 3'd2;
    localparam logic [2:0] RK_RST       = 3'd3;
    localparam logic [2:0] RK_FIN       = 3'd4;
    localparam logic [2:0] RK_SYNACK    = 3'd5;
    localparam logic [2:0] RK_DATA      = 3'd6;

    localparam logic [3:0] EV_NONE      = 4'd0;
    localparam logic [3:0] EV_CONNECTED = 4'd1;
    localparam logic [3:0] EV_DATA      = 4'd2;
    localparam logic [3:0] EV_CLOSING   = 4'd3;
    localparam logic [3:0] EV_CLOSED    = 4'd4;
    localparam logic [3:0] EV_RESET     = 4'd5;
    localparam logic [3:0] EV_DUP       = 4'd6;
    localparam logic [3:0] EV_OUTSIDE   = 4'd7;
    localparam logic [3:0] EV_BUFFERED  = 4'd8;
    localparam logic [3:0] EV_IGNORED   = 4'd9;

    localparam logic [2:0] WIN_NEXT      = 3'd0;
    localparam logic [2:0] WIN_CHALLENGE = 3'd1;
    localparam logic [2:0] WIN_BEFORE    = 3'd2;
    localparam logic [2:0] WIN_LATER     = 3'd3;
    localparam logic [2:0] WIN_AFTER     = 3'd4;

    localparam logic [2:0] EXP_KEEP    = 3'd0;
    localparam logic [2:0] EXP_SEQ1    = 3'd1;
    localparam logic [2:0] EXP_ADD_SEG = 3'd2;
    localparam logic [2:0] EXP_ADD_ENT = 3'd3;
    localparam logic [2:0] EXP_INC     = 3'd4;

    localparam logic [1:0] NSS_KEEP    = 2'd0;
    localparam logic [1:0] NSS_INIT1   = 2'd1;
    localparam logic [1:0] NSS_INC     = 2'd2;
    localparam logic [1:0] NSS_ADD_LEN = 2'd3;

    localparam logic [2:0] SRC_EVENT    = 3'd0;
    localparam logic [2:0] SRC_SESSION  = 3'd1;
    localparam logic [2:0] SRC_SLRST    = 3'd2;
    localparam logic [2:0] SRC_DATA_IN  = 3'd3;
    localparam logic [2:0] SRC_DATA_ENT = 3'd4;

    localparam logic [1:0] RS_NSS    = 2'd0;
    localparam logic [1:0] RS_NSS_M1 = 2'd1;
    localparam logic [1:0] RS_INIT   = 2'd2;

    typedef struct packed {
        logic       latch;
        logic       st_we;
        logic [2:0] st_val;
        logic [2:0] exp_op;
        logic [1:0] nss_op;
        logic       emit;
        logic [2:0] em_src;
        logic [2:0] em_kind;
        logic [3:0] em_ev;
        logic [1:0] em_seqsel;
        logic       finish;
        logic       scan_clr;
        logic       scan_step;
        logic       tab_wr;
        logic       tab_inv;
    } cmd_t;

    typedef struct packed {
        logic [2:0] conn;
        logic [1:0] req;
        logic [2:0] cls;
        logic       syn;
        logic       ack;
        logic       fin;
        logic       rst;
        logic       len_nz;
        logic [1:0] act;
        logic       ack_beyond;
        logic       hit_exp;
        logic       idx_last;
        logic       buf_found;
        logic       free_found;
        logic       ent_len_nz;
        logic       ent_fin;
        logic       exp_ne_las;
        logic       pend_valid;
        logic       out_free;
    } status_t;

endpackage

### hw/rtl/tcp_receive_session_fsm.sv
// ---------------------------------------------------------------------------
// tcp_receive_session_fsm
// Server side of one TCP connection: state, window test, reorder chaining.
// ---------------------------------------------------------------------------
// Usage:
//  Input channel (in_valid/in_stall) carries one request per beat: a received
//  segment header, an application send or an application close. Output
//  channel (out_valid/out_stall) returns one or more result beats per
//  request; the final one has last set.
//  A request is taken only when the previous one has issued all its results
//  into the output stage; in_stall is high while a request is in progress.
//  Simple requests pass through accept, dispatch and finish. An in-order
//  segment in the established state adds a reply step and, unless it carries
//  FIN, a serial table scan plus a further scan for each chained descriptor,
//  at most 9 per request. A FIN or a completed handshake adds a further step.
//  A segment buffered out of order adds a full table scan and a buffering
//  step. A result that waits on out_stall holds the request longer.
//  When out_stall is high the sequencer waits with its next result held;
//  nothing is dropped.
//  Reset puts the session in listen, clears sequence state and marks every
//  reorder entry invalid. The user must write registers through cfg_we/
//  cfg_index/cfg_data only while idle; the block itself does not enforce it.
// ---------------------------------------------------------------------------
module tcp_receive_session_fsm #(
    parameter int REORDER_DEPTH = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  req_type,
    input  logic [31:0] seg_seq,
    input  logic [31:0] seg_ack_num,
    input  logic        flag_syn,
    input  logic        flag_ack,
    input  logic        flag_fin,
    input  logic        flag_rst,
    input  logic [15:0] payload_len,
    input  logic [15:0] peer_window_adv,
    input  logic [1:0]  app_action,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  reply_kind,
    output logic [31:0] reply_seq,
    output logic [31:0] reply_ack,
    output logic [3:0]  event_code,
    output logic [31:0] deliver_seq,
    output logic [15:0] deliver_len,
    output logic [2:0]  conn_state,
    output logic        last
);
    import trs_pkg::*;

    cmd_t    cmd;
    status_t st;
    logic [15:0] peer_win_reg;

    // advertised window kept for the session; no result depends on it
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            peer_win_reg <= peer_window_adv;
        end
    end

    trs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .st       (st),
        .cmd      (cmd)
    );

    trs_dp #(
        .REORDER_DEPTH (REORDER_DEPTH)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .req_type    (req_type),
        .seg_seq     (seg_seq),
        .seg_ack_num (seg_ack_num),
        .flag_syn    (flag_syn),
        .flag_ack    (flag_ack),
        .flag_fin    (flag_fin),
        .flag_rst    (flag_rst),
        .payload_len (payload_len),
        .app_action  (app_action),
        .cmd         (cmd),
        .st          (st),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .reply_kind  (reply_kind),
        .reply_seq   (reply_seq),
        .reply_ack   (reply_ack),
        .event_code  (event_code),
        .deliver_seq (deliver_seq),
        .deliver_len (deliver_len),
        .conn_state  (conn_state),
        .last        (last)
    );

    a_win_stable: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |=> $stable(peer_win_reg))
        else $error("window captured while busy");
endmodule

### hw/rtl/trs_ctrl.sv
// ---------------------------------------------------------------------------
// trs_ctrl
// Sequencer: walks one request through dispatch, table scans and replies.
// ---------------------------------------------------------------------------
module trs_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  trs_pkg::status_t st,
    output trs_pkg::cmd_t    cmd
);
    import trs_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_DISP  = 4'd1;
    localparam logic [3:0] S_SR2   = 4'd2;
    localparam logic [3:0] S_EFIN  = 4'd3;
    localparam logic [3:0] S_CSCAN = 4'd4;
    localparam logic [3:0] S_CHIT  = 4'd5;
    localparam logic [3:0] S_CFIN  = 4'd6;
    localparam logic [3:0] S_BSCAN = 4'd7;
    localparam logic [3:0] S_BDONE = 4'd8;
    localparam logic [3:0] S_RST   = 4'd9;
    localparam logic [3:0] S_TAIL  = 4'd10;
    localparam logic [3:0] S_FIN   = 4'd11;

    localparam logic [3:0] CHAIN_LAST = 4'(CHAIN_LIMIT);

    logic [3:0] cs_reg, cs_next;
    logic [1:0] op_reg, op_next;
    logic       any_reg, any_next;
    logic [3:0] cnt_reg, cnt_next;
    cmd_t       cr;
    logic       blocked;

    function automatic cmd_t ev_cmd(input logic [3:0] ev);
        cmd_t c;
        c = '0;
        c.emit = 1'b1;
        c.em_src = SRC_EVENT;
        c.em_ev = ev;
        return c;
    endfunction

    function automatic cmd_t sess_cmd(input logic [2:0] kind, input logic [1:0] sel);
        cmd_t c;
        c = '0;
        c.emit = 1'b1;
        c.em_src = SRC_SESSION;
        c.em_kind = kind;
        c.em_seqsel = sel;
        return c;
    endfunction

    function automatic cmd_t rst_cmd();
        cmd_t c;
        c = sess_cmd(RK_RST, RS_NSS);
        c.st_we = 1'b1;
        c.st_val = ST_CLOSED;
        return c;
    endfunction

    function automatic cmd_t fin_cmd(input logic [2:0] conn);
        cmd_t c;
        c = sess_cmd(RK_FIN, RS_NSS);
        c.nss_op = NSS_INC;
        c.st_we = 1'b1;
        if (conn == ST_ESTABLISHED)
        begin
            c.st_val = ST_FIN_WAIT_1;
        end
        else if (conn == ST_CLOSE_WAIT)
        begin
            c.st_val = ST_LAST_ACK;
        end
        else
        begin
            c = ev_cmd(EV_IGNORED);
        end
        return c;
    endfunction

    always_comb
    begin
        cr = '0;
        cs_next = cs_reg;
        op_next = op_reg;
        any_next = any_reg;
        cnt_next = cnt_reg;
        case (cs_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cr.latch = 1'b1;
                    cs_next = S_DISP;
                end
            end
            S_DISP:
            begin
                op_next = ACT_OK;
                any_next = 1'b0;
                cnt_next = '0;
                cs_next = S_FIN;
                case (st.req)
                    REQ_SEG:
                    begin
                        case (st.conn)
                            ST_LISTEN:
                            begin
                                if (st.rst)
                                begin
                                    cr = ev_cmd(EV_IGNORED);
                                end
                                else if (!st.syn || st.ack || st.act != ACT_OK)
                                begin
                                    cr = ev_cmd(EV_NONE);
                                    cr.em_src = SRC_SLRST;
                                end
                                else
                                begin
                                    cr = sess_cmd(RK_SYNACK, RS_INIT);
                                    cr.st_we = 1'b1;
                                    cr.st_val = ST_SYN_RCVD;
                                    cr.exp_op = EXP_SEQ1;
                                    cr.nss_op = NSS_INIT1;
                                end
                            end
                            ST_CLOSED:
                            begin
                                cr = ev_cmd(EV_NONE);
                                cr.em_src = SRC_SLRST;
                            end
                            ST_TIME_WAIT, ST_FIN_WAIT_1:
                            begin
                                cr = ev_cmd(EV_IGNORED);
                            end
                            default:
                            begin
                                case (st.cls)
                                    WIN_CHALLENGE: cr = sess_cmd(RK_CHALLENGE, RS_NSS);
                                    WIN_BEFORE:    cr = ev_cmd(EV_DUP);
                                    WIN_AFTER:     cr = ev_cmd(EV_OUTSIDE);
                                    WIN_LATER:
                                    begin
                                        if (st.ack && st.ack_beyond)
                                        begin
                                            cr = rst_cmd();
                                        end
                                        else if (st.len_nz || st.fin)
                                        begin
                                            cr.scan_clr = 1'b1;
                                            cs_next = S_BSCAN;
                                        end
                                    end
                                    default:
                                    begin
                                        if (st.conn == ST_ESTABLISHED && !st.ack && !st.rst)
                                        begin
                                            cr = ev_cmd(EV_IGNORED);
                                        end
                                        else if (st.rst)
                                        begin
                                            cr = ev_cmd(EV_RESET);
                                            cr.st_we = 1'b1;
                                            cr.st_val = ST_CLOSED;
                                            cr.exp_op = EXP_ADD_SEG;
                                        end
                                        else
                                        begin
                                            case (st.conn)
                                                ST_CLOSE_WAIT:
                                                begin
                                                    if (st.fin)
                                                    begin
                                                        cr = ev_cmd(EV_CLOSED);
                                                        cr.st_we = 1'b1;
                                                        cr.st_val = ST_CLOSED;
                                                    end
                                                    cr.exp_op = EXP_ADD_SEG;
                                                end
                                                ST_LAST_ACK:
                                                begin
                                                    cr.exp_op = EXP_ADD_SEG;
                                                    cr.st_we = st.ack;
                                                    cr.st_val = ST_CLOSED;
                                                end
                                                ST_SYN_RCVD:
                                                begin
                                                    if (!st.ack || st.fin)
                                                    begin
                                                        cr = rst_cmd();
                                                        cr.exp_op = EXP_ADD_SEG;
                                                    end
                                                    else if (st.syn)
                                                    begin
                                                        cr = sess_cmd(RK_SYNACK, RS_NSS_M1);
                                                        cr.exp_op = EXP_SEQ1;
                                                    end
                                                    else
                                                    begin
                                                        cr = ev_cmd(EV_CONNECTED);
                                                        cr.st_we = 1'b1;
                                                        cr.st_val = ST_ESTABLISHED;
                                                        cr.exp_op = EXP_ADD_SEG;
                                                        op_next = st.act;
                                                        any_next = st.len_nz;
                                                        cs_next = S_SR2;
                                                    end
                                                end
                                                default:
                                                begin
                                                    if (st.len_nz)
                                                    begin
                                                        cr = ev_cmd(EV_DATA);
                                                        cr.em_src = SRC_DATA_IN;
                                                        op_next = st.act;
                                                    end
                                                    cr.exp_op = EXP_ADD_SEG;
                                                    any_next = st.len_nz || st.fin;
                                                    if (st.fin)
                                                    begin
                                                        cs_next = S_EFIN;
                                                    end
                                                    else if (st.len_nz && st.act == ACT_RST)
                                                    begin
                                                        cs_next = S_RST;
                                                    end
                                                    else
                                                    begin
                                                        cr.scan_clr = 1'b1;
                                                        cs_next = S_CSCAN;
                                                    end
                                                end
                                            endcase
                                        end
                                    end
                                endcase
                            end
                        endcase
                    end
                    REQ_SEND:
                    begin
                        if (st.conn == ST_ESTABLISHED || st.conn == ST_CLOSE_WAIT)
                        begin
                            cr = sess_cmd(RK_DATA, RS_NSS);
                            cr.nss_op = NSS_ADD_LEN;
                        end
                        else
                        begin
                            cr = ev_cmd(EV_IGNORED);
                        end
                    end
                    REQ_CLOSE: cr = fin_cmd(st.conn);
                    default:   cr = ev_cmd(EV_IGNORED);
                endcase
            end
            S_SR2:
            begin
                if (st.act == ACT_RST)
                begin
                    cr = rst_cmd();
                    cs_next = S_FIN;
                end
                else
                begin
                    if (st.len_nz)
                    begin
                        cr = ev_cmd(EV_DATA);
                        cr.em_src = SRC_DATA_IN;
                    end
                    cs_next = S_TAIL;
                end
            end
            S_EFIN:
            begin
                cr = ev_cmd(EV_CLOSING);
                cr.st_we = 1'b1;
                cr.st_val = ST_CLOSE_WAIT;
                op_next = st.act;
                cs_next = (st.act == ACT_RST) ? S_RST : S_TAIL;
            end
            S_CSCAN:
            begin
                if (st.hit_exp)
                begin
                    cs_next = S_CHIT;
                end
                else if (st.idx_last)
                begin
                    cs_next = S_TAIL;
                end
                else
                begin
                    cr.scan_step = 1'b1;
                end
            end
            S_CHIT:
            begin
                if (st.ent_len_nz)
                begin
                    cr = ev_cmd(EV_DATA);
                    cr.em_src = SRC_DATA_ENT;
                    op_next = st.act;
                end
                cr.tab_inv = 1'b1;
                cr.exp_op = EXP_ADD_ENT;
                any_next = 1'b1;
                cnt_next = cnt_reg + 4'd1;
                if (st.ent_len_nz && st.act == ACT_RST)
                begin
                    cs_next = S_RST;
                end
                else if (st.ent_fin)
                begin
                    cs_next = S_CFIN;
                end
                else if (cnt_reg + 4'd1 == CHAIN_LAST)
                begin
                    cs_next = S_TAIL;
                end
                else
                begin
                    cr.scan_clr = 1'b1;
                    cs_next = S_CSCAN;
                end
            end
            S_CFIN:
            begin
                cr = ev_cmd(EV_CLOSING);
                cr.exp_op = EXP_INC;
                cr.st_we = 1'b1;
                cr.st_val = ST_CLOSE_WAIT;
                op_next = st.act;
                cs_next = (st.act == ACT_RST) ? S_RST : S_TAIL;
            end
            S_BSCAN:
            begin
                cr.scan_step = 1'b1;
                if (st.idx_last)
                begin
                    cs_next = S_BDONE;
                end
            end
            S_BDONE:
            begin
                if (st.buf_found)
                begin
                    cr = ev_cmd(EV_BUFFERED);
                end
                else if (st.free_found)
                begin
                    cr = ev_cmd(EV_BUFFERED);
                    cr.tab_wr = 1'b1;
                end
                else
                begin
                    cr = ev_cmd(EV_IGNORED);
                end
                cs_next = S_FIN;
            end
            S_RST:
            begin
                cr = rst_cmd();
                cs_next = S_FIN;
            end
            S_TAIL:
            begin
                if (op_reg == ACT_FIN)
                begin
                    cr = fin_cmd(st.conn);
                end
                else if (any_reg && st.exp_ne_las)
                begin
                    cr = sess_cmd(RK_ACK, RS_NSS);
                end
                cs_next = S_FIN;
            end
            S_FIN:
            begin
                cr.finish = 1'b1;
                cs_next = S_IDLE;
            end
            default: cs_next = S_IDLE;
        endcase
    end

    assign blocked = (cr.emit && st.pend_valid && !st.out_free) || (cr.finish && !st.out_free);
    assign cmd = blocked ? '0 : cr;
    assign in_stall = (cs_reg != S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cs_reg <= S_IDLE;
            op_reg <= ACT_OK;
            any_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else if (!blocked)
        begin
            cs_reg <= cs_next;
            op_reg <= op_next;
            any_reg <= any_next;
            cnt_reg <= cnt_next;
        end
    end

    a_latch_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.latch |-> cs_reg == S_IDLE)
        else $error("input latched outside idle");
    a_disp_follows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.latch |=> cs_reg == S_DISP)
        else $error("dispatch did not follow accept");
    a_chain_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cs_reg == S_CHIT |-> cnt_reg < CHAIN_LAST)
        else $error("chain limit exceeded");
endmodule

### hw/rtl/trs_dp.sv
// ---------------------------------------------------------------------------
// trs_dp
// Session registers, reorder table, window test and result staging.
// ---------------------------------------------------------------------------
module trs_dp #(
    parameter int REORDER_DEPTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [0:0]       cfg_index,
    input  logic [31:0]      cfg_data,
    input  logic [1:0]       req_type,
    input  logic [31:0]      seg_seq,
    input  logic [31:0]      seg_ack_num,
    input  logic             flag_syn,
    input  logic             flag_ack,
    input  logic             flag_fin,
    input  logic             flag_rst,
    input  logic [15:0]      payload_len,
    input  logic [1:0]       app_action,
    input  trs_pkg::cmd_t    cmd,
    output trs_pkg::status_t st,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [2:0]       reply_kind,
    output logic [31:0]      reply_seq,
    output logic [31:0]      reply_ack,
    output logic [3:0]       event_code,
    output logic [31:0]      deliver_seq,
    output logic [15:0]      deliver_len,
    output logic [2:0]       conn_state,
    output logic             last
);
    import trs_pkg::*;

    localparam int IW = (REORDER_DEPTH > 1) ? $clog2(REORDER_DEPTH) : 1;
    localparam logic [IW-1:0] IDX_LAST = IW'(REORDER_DEPTH - 1);

    logic [1:0]  req_reg;
    logic [31:0] seq_reg, ackn_reg;
    logic        syn_reg, ack_reg, fin_reg, rst_reg;
    logic [15:0] len_reg;
    logic [1:0]  act_reg;

    logic [15:0] rwin_reg;
    logic [31:0] iss_reg;
    logic [2:0]  conn_reg, conn_next;
    logic [31:0] exp_reg, exp_next;
    logic [31:0] nss_reg, nss_next;
    logic [31:0] las_reg;

    logic [REORDER_DEPTH-1:0] vld_reg;
    logic [31:0] tseq_mem [REORDER_DEPTH];
    logic [15:0] tlen_mem [REORDER_DEPTH];
    logic        tfin_mem [REORDER_DEPTH];
    logic [IW-1:0] idx_reg, free_idx_reg;
    logic        found_reg, free_found_reg;

    logic [31:0] ent_seq;
    logic [15:0] ent_len;
    logic        hit_seq;
    logic [31:0] dwin, dack;

    logic        pend_valid_reg;
    logic [2:0]  pend_kind_reg, pend_conn_reg;
    logic [31:0] pend_seq_reg, pend_ack_reg, pend_dseq_reg;
    logic [3:0]  pend_ev_reg;
    logic [15:0] pend_dlen_reg;

    logic [2:0]  em_kind;
    logic [31:0] em_seq, em_ack, em_dseq;
    logic [3:0]  em_ev;
    logic [15:0] em_dlen;

    logic        out_valid_reg, out_last_reg, out_load, out_free;
    logic [2:0]  out_kind_reg, out_conn_reg;
    logic [31:0] out_seq_reg, out_ack_reg, out_dseq_reg;
    logic [3:0]  out_ev_reg;
    logic [15:0] out_dlen_reg;

    assign ent_seq = tseq_mem[idx_reg];
    assign ent_len = tlen_mem[idx_reg];
    assign hit_seq = vld_reg[idx_reg] && (ent_seq == seq_reg);
    assign dwin = seq_reg - exp_reg;
    assign dack = ackn_reg - nss_reg;
    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        st = '0;
        st.conn = conn_reg;
        st.req = req_reg;
        if (dwin == 32'd0)
        begin
            st.cls = WIN_NEXT;
        end
        else if (rst_reg)
        begin
            st.cls = WIN_CHALLENGE;
        end
        else if (dwin[31])
        begin
            st.cls = WIN_BEFORE;
        end
        else if (dwin < {16'd0, rwin_reg})
        begin
            st.cls = WIN_LATER;
        end
        else
        begin
            st.cls = WIN_AFTER;
        end
        st.syn = syn_reg;
        st.ack = ack_reg;
        st.fin = fin_reg;
        st.rst = rst_reg;
        st.len_nz = (len_reg != 16'd0);
        st.act = act_reg;
        st.ack_beyond = (dack != 32'd0) && !dack[31];
        st.hit_exp = vld_reg[idx_reg] && (ent_seq == exp_reg);
        st.idx_last = (idx_reg == IDX_LAST);
        st.buf_found = found_reg;
        st.free_found = free_found_reg;
        st.ent_len_nz = (ent_len != 16'd0);
        st.ent_fin = tfin_mem[idx_reg];
        st.exp_ne_las = (exp_reg != las_reg);
        st.pend_valid = pend_valid_reg;
        st.out_free = out_free;
    end

    always_comb
    begin
        case (cmd.exp_op)
            EXP_SEQ1:    exp_next = seq_reg + 32'd1;
            EXP_ADD_SEG: exp_next = exp_reg + {16'd0, len_reg} + {31'd0, fin_reg};
            EXP_ADD_ENT: exp_next = exp_reg + {16'd0, ent_len};
            EXP_INC:     exp_next = exp_reg + 32'd1;
            default:     exp_next = exp_reg;
        endcase
        case (cmd.nss_op)
            NSS_INIT1:   nss_next = iss_reg + 32'd1;
            NSS_INC:     nss_next = nss_reg + 32'd1;
            NSS_ADD_LEN: nss_next = nss_reg + {16'd0, len_reg};
            default:     nss_next = nss_reg;
        endcase
        conn_next = cmd.st_we ? cmd.st_val : conn_reg;
    end

    always_comb
    begin
        em_kind = RK_NONE;
        em_seq = '0;
        em_ack = '0;
        em_ev = EV_NONE;
        em_dseq = '0;
        em_dlen = '0;
        case (cmd.em_src)
            SRC_EVENT: em_ev = cmd.em_ev;
            SRC_SESSION:
            begin
                em_kind = cmd.em_kind;
                em_ack = exp_next;
                case (cmd.em_seqsel)
                    RS_NSS_M1: em_seq = nss_reg - 32'd1;
                    RS_INIT:   em_seq = iss_reg;
                    default:   em_seq = nss_reg;
                endcase
            end
            SRC_SLRST:
            begin
                em_kind = RK_RST;
                if (ack_reg)
                begin
                    em_seq = ackn_reg;
                end
                else
                begin
                    em_ack = seq_reg + {16'd0, len_reg} + {31'd0, syn_reg}
                           + {31'd0, fin_reg};
                end
            end
            SRC_DATA_IN:
            begin
                em_ev = EV_DATA;
                em_dseq = seq_reg;
                em_dlen = len_reg;
            end
            SRC_DATA_ENT:
            begin
                em_ev = EV_DATA;
                em_dseq = ent_seq;
                em_dlen = ent_len;
            end
            default: em_ev = EV_NONE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            req_reg <= req_type;
            seq_reg <= seg_seq;
            ackn_reg <= seg_ack_num;
            syn_reg <= flag_syn;
            ack_reg <= flag_ack;
            fin_reg <= flag_fin;
            rst_reg <= flag_rst;
            len_reg <= payload_len;
            act_reg <= (app_action == ACT_BAD) ? ACT_OK : app_action;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rwin_reg <= 16'hFFFF;
            iss_reg <= '0;
            conn_reg <= ST_LISTEN;
            exp_reg <= '0;
            nss_reg <= '0;
            las_reg <= '0;
        end
        else
        begin
            if (cfg_we && cfg_index == CFG_RECV_WIN)
            begin
                rwin_reg <= cfg_data[15:0];
            end
            if (cfg_we && cfg_index == CFG_INIT_SEQ)
            begin
                iss_reg <= cfg_data;
            end
            conn_reg <= conn_next;
            exp_reg <= exp_next;
            nss_reg <= nss_next;
            if (cmd.emit && cmd.em_src == SRC_SESSION)
            begin
                las_reg <= exp_next;
            end
        end
    end

    // reorder table: valid bits reset, descriptors do not
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
            idx_reg <= '0;
            free_idx_reg <= '0;
            found_reg <= 1'b0;
            free_found_reg <= 1'b0;
        end
        else
        begin
            if (cmd.scan_clr)
            begin
                idx_reg <= '0;
                found_reg <= 1'b0;
                free_found_reg <= 1'b0;
            end
            else if (cmd.scan_step)
            begin
                found_reg <= found_reg | hit_seq;
                if (!vld_reg[idx_reg] && !free_found_reg)
                begin
                    free_found_reg <= 1'b1;
                    free_idx_reg <= idx_reg;
                end
                if (idx_reg != IDX_LAST)
                begin
                    idx_reg <= idx_reg + 1'b1;
                end
            end
            if (cmd.tab_wr)
            begin
                vld_reg[free_idx_reg] <= 1'b1;
            end
            if (cmd.tab_inv)
            begin
                vld_reg[idx_reg] <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.tab_wr)
        begin
            tseq_mem[free_idx_reg] <= seq_reg;
            tlen_mem[free_idx_reg] <= len_reg;
            tfin_mem[free_idx_reg] <= fin_reg;
        end
    end

    // one result held back so that the final one can carry last
    assign out_load = cmd.finish || (cmd.emit && pend_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.finish)
            begin
                pend_valid_reg <= 1'b0;
            end
            else if (cmd.emit)
            begin
                pend_valid_reg <= 1'b1;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            pend_kind_reg <= em_kind;
            pend_seq_reg <= em_seq;
            pend_ack_reg <= em_ack;
            pend_ev_reg <= em_ev;
            pend_dseq_reg <= em_dseq;
            pend_dlen_reg <= em_dlen;
            pend_conn_reg <= conn_next;
        end
        if (out_load)
        begin
            out_last_reg <= cmd.finish;
            if (pend_valid_reg)
            begin
                out_kind_reg <= pend_kind_reg;
                out_seq_reg <= pend_seq_reg;
                out_ack_reg <= pend_ack_reg;
                out_ev_reg <= pend_ev_reg;
                out_dseq_reg <= pend_dseq_reg;
                out_dlen_reg <= pend_dlen_reg;
                out_conn_reg <= pend_conn_reg;
            end
            else
            begin
                out_kind_reg <= RK_NONE;
                out_seq_reg <= '0;
                out_ack_reg <= '0;
                out_ev_reg <= EV_NONE;
                out_dseq_reg <= '0;
                out_dlen_reg <= '0;
                out_conn_reg <= conn_reg;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign reply_kind = out_kind_reg;
    assign reply_seq = out_seq_reg;
    assign reply_ack = out_ack_reg;
    assign event_code = out_ev_reg;
    assign deliver_seq = out_dseq_reg;
    assign deliver_len = out_dlen_reg;
    assign conn_state = out_conn_reg;
    assign last = out_last_reg;

    a_pend_safe: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit && pend_valid_reg |-> out_free)
        else $error("held result overwritten");
    a_finish_safe: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> out_free)
        else $error("finish while output busy");
    a_finish_last: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> out_valid_reg && out_last_reg && !pend_valid_reg)
        else $error("final beat not marked");
    a_wr_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.tab_wr |-> !vld_reg[free_idx_reg])
        else $error("reorder write over live entry");
endmodule

### bench/tb.sv
// ---------------------------------------------------------------------------
// TCP receive session bench
// Walks one connection from listen through handshake, a long established
// stretch with reordered, duplicate, out-of-window and challenged segments,
// then close wait, last ack and closed. Each accepted request is run through
// an in-bench session model; every result beat is checked against it.
// ---------------------------------------------------------------------------
module tb;
    import trs_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = 8;
    localparam int CYCLE_LIMIT = 1000000;

    typedef struct {
        logic [1:0]  req;
        logic [31:0] seq;
        logic [31:0] ackn;
        logic        syn;
        logic        ack;
        logic        fin;
        logic        rst;
        logic [15:0] len;
        logic [15:0] wnd;
        logic [1:0]  act;
    } seg_req_t;

    typedef struct {
        logic [2:0]  kind;
        logic [31:0] rseq;
        logic [31:0] rack;
        logic [3:0]  ev;
        logic [31:0] dseq;
        logic [15:0] dlen;
        logic [2:0]  st;
        logic        lst;
    } sess_res_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [0:0]  cfg_index;
    logic [31:0] cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  req_type;
    logic [31:0] seg_seq;
    logic [31:0] seg_ack_num;
    logic        flag_syn;
    logic        flag_ack;
    logic        flag_fin;
    logic        flag_rst;
    logic [15:0] payload_len;
    logic [15:0] peer_window_adv;
    logic [1:0]  app_action;
    logic        out_valid;
    logic        out_stall;
    logic [2:0]  reply_kind;
    logic [31:0] reply_seq;
    logic [31:0] reply_ack;
    logic [3:0]  event_code;
    logic [31:0] deliver_seq;
    logic [15:0] deliver_len;
    logic [2:0]  conn_state;
    logic        last;

    tcp_receive_session_fsm #(.REORDER_DEPTH(DEPTH)) dut (.*);

    // session model state
    logic [15:0] m_rwin;
    logic [31:0] m_iss;
    logic [2:0]  m_state;
    logic [31:0] m_exp;
    logic [31:0] m_nss;
    logic [15:0] m_pwin;
    logic [31:0] m_lpa;
    logic [31:0] m_las;
    logic        tab_v   [DEPTH];
    logic [31:0] tab_seq [DEPTH];
    logic [15:0] tab_len [DEPTH];
    logic        tab_fin [DEPTH];

    sess_res_t step_res[$];
    sess_res_t pending_res[$];

    int errors = 0;
    int cycles = 0;
    int gap_pct = 0;
    int stall_pct = 0;
    int hold_left = 0;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // ---------------- session model ----------------
    function automatic void note(logic [2:0] kind, logic [31:0] rseq, logic [31:0] rack,
                                 logic [3:0] ev, logic [31:0] dseq, logic [15:0] dlen);
        sess_res_t r;
        if (step_res.size() >= 12)
            return;
        r.kind = kind; r.rseq = rseq; r.rack = rack; r.ev = ev;
        r.dseq = dseq; r.dlen = dlen; r.st = m_state; r.lst = 1'b0;
        step_res.push_back(r);
    endfunction

    function automatic void note_event(logic [3:0] ev);
        note(RK_NONE, 0, 0, ev, 0, 0);
    endfunction

    function automatic void reply(logic [2:0] kind, logic [31:0] s);
        m_las = m_exp;
        note(kind, s, m_exp, EV_NONE, 0, 0);
    endfunction

    function automatic void abort_session();
        m_state = ST_CLOSED;
        reply(RK_RST, m_nss);
    endfunction

    function automatic void close_session();
        logic [31:0] s;
        s = m_nss;
        if (m_state == ST_ESTABLISHED)
            m_state = ST_FIN_WAIT_1;
        else if (m_state == ST_CLOSE_WAIT)
            m_state = ST_LAST_ACK;
        else
        begin
            note_event(EV_IGNORED);
            return;
        end
        m_nss = s + 1;
        reply(RK_FIN, s);
    endfunction

    function automatic void bare_rst(seg_req_t r);
        if (r.ack)
            note(RK_RST, r.ackn, 0, EV_NONE, 0, 0);
        else
            note(RK_RST, 0, r.seq + {16'd0, r.len} + r.syn + r.fin, EV_NONE, 0, 0);
    endfunction

    function automatic logic [2:0] window_class(logic [31:0] s, logic rst);
        logic [31:0] d;
        d = s - m_exp;
        if (d == 0)
            return WIN_NEXT;
        if (rst)
            return WIN_CHALLENGE;
        if (d[31])
            return WIN_BEFORE;
        if (d < {16'd0, m_rwin})
            return WIN_LATER;
        return WIN_AFTER;
    endfunction

    function automatic int slot_of(logic [31:0] s);
        for (int i = 0; i < DEPTH; i++)
            if (tab_v[i] && tab_seq[i] == s)
                return i;
        return -1;
    endfunction

    function automatic void stash(logic [31:0] s, logic [15:0] len, logic fin);
        if (slot_of(s) >= 0)
        begin
            note_event(EV_BUFFERED);
            return;
        end
        for (int i = 0; i < DEPTH; i++)
            if (!tab_v[i])
            begin
                tab_v[i] = 1'b1; tab_seq[i] = s; tab_len[i] = len; tab_fin[i] = fin;
                note_event(EV_BUFFERED);
                return;
            end
        note_event(EV_IGNORED);
    endfunction

    function automatic void deliver_in_order(seg_req_t r, logic [1:0] act);
        logic [1:0]  op;
        logic        chained;
        logic [31:0] target;
        int          idx;
        logic [31:0] e_seq;
        logic [15:0] e_len;
        logic        e_fin;
        op = ACT_OK;
        chained = 1'b0;
        if (r.len != 0)
        begin
            note(RK_NONE, 0, 0, EV_DATA, r.seq, r.len);
            op = act;
        end
        if (r.fin)
        begin
            m_state = ST_CLOSE_WAIT;
            note_event(EV_CLOSING);
            op = act;
        end
        if (op == ACT_RST)
        begin
            abort_session();
            return;
        end
        if (!r.fin)
        begin
            target = r.seq + {16'd0, r.len};
            for (int n = 0; n < CHAIN_LIMIT; n++)
            begin
                idx = slot_of(target);
                if (idx < 0)
                    break;
                e_seq = tab_seq[idx]; e_len = tab_len[idx]; e_fin = tab_fin[idx];
                tab_v[idx] = 1'b0;
                chained = 1'b1;
                if (e_len != 0)
                begin
                    note(RK_NONE, 0, 0, EV_DATA, e_seq, e_len);
                    op = act;
                end
                m_exp = m_exp + {16'd0, e_len};
                if (op == ACT_RST)
                begin
                    abort_session();
                    return;
                end
                if (e_fin)
                begin
                    m_exp = m_exp + 1;
                    m_state = ST_CLOSE_WAIT;
                    note_event(EV_CLOSING);
                    op = act;
                    if (op == ACT_RST)
                    begin
                        abort_session();
                        return;
                    end
                    break;
                end
                target = target + {16'd0, e_len};
            end
        end
        if (op == ACT_FIN)
            close_session();
        else if ((r.len != 0 || r.fin || chained) && m_exp != m_las)
            reply(RK_ACK, m_nss);
    endfunction

    function automatic void take_segment(seg_req_t r, logic [1:0] act);
        logic [31:0] d;
        case (m_state)
            ST_LISTEN:
            begin
                if (r.rst)
                begin
                    note_event(EV_IGNORED);
                    return;
                end
                if (!r.syn || r.ack || act != ACT_OK)
                begin
                    bare_rst(r);
                    return;
                end
                m_nss = m_iss;
                m_state = ST_SYN_RCVD;
                m_exp = r.seq + 1;
                m_pwin = r.wnd;
                reply(RK_SYNACK, m_nss);
                m_nss = m_nss + 1;
                return;
            end
            ST_CLOSED:
            begin
                bare_rst(r);
                return;
            end
            ST_TIME_WAIT, ST_FIN_WAIT_1:
            begin
                note_event(EV_IGNORED);
                return;
            end
            default: ;
        endcase

        case (window_class(r.seq, r.rst))
            WIN_CHALLENGE:
            begin
                reply(RK_CHALLENGE, m_nss);
                return;
            end
            WIN_BEFORE:
            begin
                note_event(EV_DUP);
                return;
            end
            WIN_AFTER:
            begin
                note_event(EV_OUTSIDE);
                return;
            end
            WIN_LATER:
            begin
                if (r.ack)
                begin
                    d = r.ackn - m_nss;
                    if (d != 0 && !d[31])
                    begin
                        abort_session();
                        return;
                    end
                    m_lpa = r.ackn;
                end
                if (r.len != 0 || r.fin)
                    stash(r.seq, r.len, r.fin);
                return;
            end
            default: ;
        endcase

        if (m_state == ST_ESTABLISHED && !r.ack && !r.rst)
        begin
            note_event(EV_IGNORED);
            return;
        end
        m_exp = m_exp + {16'd0, r.len} + r.fin;
        m_pwin = r.wnd;
        if (r.rst)
        begin
            m_state = ST_CLOSED;
            note_event(EV_RESET);
            return;
        end

        case (m_state)
            ST_CLOSE_WAIT:
            begin
                if (r.ack)
                    m_lpa = r.ackn;
                if (r.fin)
                begin
                    m_state = ST_CLOSED;
                    note_event(EV_CLOSED);
                end
            end
            ST_LAST_ACK:
            begin
                if (r.ack)
                begin
                    m_lpa = r.ackn;
                    m_state = ST_CLOSED;
                end
            end
            ST_SYN_RCVD:
            begin
                if (!r.ack || r.fin)
                begin
                    abort_session();
                    return;
                end
                if (r.syn)
                begin
                    m_exp = r.seq + 1;
                    reply(RK_SYNACK, m_nss - 1);
                    return;
                end
                m_state = ST_ESTABLISHED;
                m_lpa = r.ackn;
                note_event(EV_CONNECTED);
                if (act == ACT_RST)
                begin
                    abort_session();
                    return;
                end
                if (r.len != 0)
                    note(RK_NONE, 0, 0, EV_DATA, r.seq, r.len);
                if (act == ACT_FIN)
                    close_session();
                else if (r.len != 0 && m_exp != m_las)
                    reply(RK_ACK, m_nss);
            end
            default:
            begin
                m_lpa = r.ackn;
                deliver_in_order(r, act);
            end
        endcase
    endfunction

    function automatic void predict_step(seg_req_t r);
        logic [1:0]  act;
        logic [31:0] s;
        act = (r.act == ACT_BAD) ? ACT_OK : r.act;
        step_res.delete();
        if (r.req == REQ_SEG)
            take_segment(r, act);
        else if (r.req == REQ_SEND)
        begin
            if (m_state == ST_ESTABLISHED || m_state == ST_CLOSE_WAIT)
            begin
                s = m_nss;
                m_nss = s + {16'd0, r.len};
                reply(RK_DATA, s);
            end
            else
                note_event(EV_IGNORED);
        end
        else if (r.req == REQ_CLOSE)
            close_session();
        else
            note_event(EV_IGNORED);
        if (step_res.size() == 0)
            note_event(EV_NONE);
        step_res[step_res.size() - 1].lst = 1'b1;
        foreach (step_res[i])
            pending_res.push_back(step_res[i]);
    endfunction

    // ---------------- driving ----------------
    task automatic send_beat(seg_req_t r);
        while ($urandom_range(99) < gap_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        req_type <= r.req; seg_seq <= r.seq; seg_ack_num <= r.ackn;
        flag_syn <= r.syn; flag_ack <= r.ack; flag_fin <= r.fin; flag_rst <= r.rst;
        payload_len <= r.len; peer_window_adv <= r.wnd; app_action <= r.act;
        do
            @(posedge clk);
        while (in_stall);
        predict_step(r);
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending_res.size() != 0)
            @(negedge clk);
        repeat (40) @(negedge clk);
    endtask

    task automatic write_reg(logic [0:0] idx, logic [31:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_RECV_WIN)
            m_rwin = val[15:0];
        else
            m_iss = val;
    endtask

    function automatic seg_req_t mk_seg(logic [31:0] s, logic [31:0] a, logic syn,
                                        logic ack, logic fin, logic rst,
                                        logic [15:0] len, logic [1:0] act);
        seg_req_t r;
        r.req = REQ_SEG; r.seq = s; r.ackn = a; r.syn = syn; r.ack = ack;
        r.fin = fin; r.rst = rst; r.len = len; r.wnd = 16'($urandom); r.act = act;
        return r;
    endfunction

    function automatic seg_req_t mk_app(logic [1:0] req, logic [15:0] len);
        seg_req_t r;
        r = mk_seg($urandom, $urandom, 1'b0, 1'b0, 1'b0, 1'b0, len, ACT_OK);
        r.req = req;
        return r;
    endfunction

    // ---------------- tests ----------------
    task automatic test_listen();
        seg_req_t r;
        send_beat(mk_seg(32'h1234_5678, 0, 1, 0, 0, 1, 16'd10, ACT_OK));
        send_beat(mk_seg(32'h0, 32'hFFFF_FFFF, 0, 1, 0, 0, 16'd0, ACT_OK));
        send_beat(mk_seg(32'hFFFF_FFFF, 0, 0, 0, 1, 0, 16'hFFFF, ACT_OK));
        send_beat(mk_seg(32'h8000_0000, 32'h5555_AAAA, 1, 1, 0, 0, 16'd1, ACT_OK));
        send_beat(mk_seg(32'h0000_1000, 0, 1, 0, 0, 0, 16'd0, ACT_RST));
        send_beat(mk_seg(32'h0000_2000, 0, 1, 0, 0, 0, 16'd0, ACT_FIN));
        send_beat(mk_app(REQ_SEND, 16'd100));
        send_beat(mk_app(REQ_CLOSE, 16'd0));
        r = mk_app(REQ_SEND, 16'd0);
        r.req = 2'd3;
        send_beat(r);
        // handshake near the top of sequence space, app answer code 3 taken as ok
        send_beat(mk_seg(32'hFFFF_FFF0, 0, 1, 0, 0, 0, 16'd0, ACT_BAD));
    endtask

    task automatic test_syn_received();
        send_beat(mk_seg(m_exp, m_nss, 1, 1, 0, 0, 16'd0, ACT_OK));
        send_beat(mk_seg(m_exp - 5, m_nss, 0, 1, 0, 0, 16'd3, ACT_OK));
        send_beat(mk_seg(m_exp + 32'h0010_0000, m_nss, 0, 1, 0, 0, 16'd3, ACT_OK));
        send_beat(mk_seg(m_exp + 7, m_nss, 0, 0, 0, 1, 16'd0, ACT_OK));
        send_beat(mk_app(REQ_SEND, 16'd50));
        send_beat(mk_seg(m_exp, m_nss, 0, 1, 0, 0, 16'd20, ACT_OK));
    endtask

    task automatic test_established(int n_items);
        int          sent;
        int          pick;
        int          m;
        int          k;
        logic [15:0] seglen;
        int          order[$];
        logic [31:0] base;
        sent = 0;
        while (sent < n_items)
        begin
            pick = $urandom_range(99);
            if (pick < 40)
            begin
                seglen = 16'($urandom_range(1, 300));
                m = $urandom_range(1, 9);
                base = m_exp;
                order.delete();
                for (int i = 1; i <= m; i++)
                    order.push_back(i);
                order.shuffle();
                foreach (order[i])
                begin
                    send_beat(mk_seg(base + seglen * order[i], m_nss, 0, 1, 0, 0,
                                     seglen, ACT_OK));
                    sent++;
                end
                if ($urandom_range(3) == 0)
                begin
                    send_beat(mk_seg(base + seglen, m_nss, 0, 1, 0, 0, seglen, ACT_OK));
                    sent++;
                end
                send_beat(mk_seg(m_exp, $urandom, 1'($urandom_range(1)), 1, 0, 0, seglen,
                                 $urandom_range(1) ? ACT_OK : ACT_BAD));
                sent++;
            end
            else
            begin
                if (pick < 55)
                    send_beat(mk_seg(m_exp, $urandom, 1'($urandom_range(1)), 1, 0, 0,
                                     $urandom_range(3) == 0 ? 16'd0
                                         : 16'($urandom_range(1, 1500)),
                                     ACT_OK));
                else if (pick < 65)
                    send_beat(mk_app(REQ_SEND, 16'($urandom)));
                else if (pick < 73)
                    send_beat(mk_seg(m_exp - $urandom_range(1, 32'h7FFF_FFFF), $urandom,
                                     1'($urandom_range(1)), 1'($urandom_range(1)),
                                     1'($urandom_range(1)), 0, 16'($urandom), ACT_OK));
                else if (pick < 80)
                    send_beat(mk_seg(m_exp + m_rwin + $urandom_range(0, 32'h7000_0000),
                                     $urandom, 0, 1, 1'($urandom_range(1)), 0,
                                     16'($urandom), ACT_OK));
                else if (pick < 86)
                    send_beat(mk_seg(m_exp + $urandom_range(1, 32'hFFFF_FFFE), $urandom,
                                     1'($urandom_range(1)), 1'($urandom_range(1)),
                                     1'($urandom_range(1)), 1, 16'($urandom), ACT_OK));
                else if (pick < 91)
                    send_beat(mk_seg(m_exp, $urandom, 0, 0, 0, 0, 16'($urandom), ACT_OK));
                else
                    send_beat(mk_seg(m_exp + $urandom_range(1, 2000),
                                     m_nss - $urandom_range(0, 1000), 0,
                                     1'($urandom_range(1)), 0, 0,
                                     16'($urandom_range(0, 400)), ACT_OK));
                sent++;
            end
        end
    endtask

    task automatic test_close_down();
        seg_req_t r;
        send_beat(mk_seg(m_exp, m_nss, 0, 1, 1, 0, 16'd10, ACT_OK));
        send_beat(mk_app(REQ_SEND, 16'hFFFF));
        send_beat(mk_seg(m_exp, m_nss, 0, 1, 0, 0, 16'd0, ACT_OK));
        send_beat(mk_app(REQ_CLOSE, 16'd0));
        send_beat(mk_seg(m_exp, m_nss, 0, 1, 0, 0, 16'd0, ACT_OK));
        // closed: everything draws a stateless reset or is ignored
        repeat (30)
        begin
            r = mk_seg($urandom, $urandom, 1'($urandom_range(1)), 1'($urandom_range(1)),
                       1'($urandom_range(1)), 1'($urandom_range(1)), 16'($urandom),
                       2'($urandom_range(3)));
            r.req = 2'($urandom_range(3));
            send_beat(r);
        end
    endtask

    // ---------------- receiver, checker, watchdog ----------------
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else
            out_stall <= ($urandom_range(99) < stall_pct);
    end

    task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
        errors++;
        $display("MISMATCH %s: expected %0h got %0h at %0t", what, want, got, $realtime);
    endtask

    always @(posedge clk)
    begin
        sess_res_t w;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_res.size() == 0)
                report_mismatch("unexpected beat, event", 32'd0, 32'(event_code));
            else
            begin
                w = pending_res.pop_front();
                if (reply_kind !== w.kind)
                    report_mismatch("reply_kind", 32'(w.kind), 32'(reply_kind));
                if (reply_seq !== w.rseq) report_mismatch("reply_seq", w.rseq, reply_seq);
                if (reply_ack !== w.rack) report_mismatch("reply_ack", w.rack, reply_ack);
                if (event_code !== w.ev)
                    report_mismatch("event_code", 32'(w.ev), 32'(event_code));
                if (deliver_seq !== w.dseq) report_mismatch("deliver_seq", w.dseq, deliver_seq);
                if (deliver_len !== w.dlen)
                    report_mismatch("deliver_len", 32'(w.dlen), 32'(deliver_len));
                if (conn_state !== w.st)
                    report_mismatch("conn_state", 32'(w.st), 32'(conn_state));
                if (last !== w.lst) report_mismatch("last", 32'(w.lst), 32'(last));
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
        in_valid = 1'b0; req_type = '0; seg_seq = '0; seg_ack_num = '0;
        flag_syn = 1'b0; flag_ack = 1'b0; flag_fin = 1'b0; flag_rst = 1'b0;
        payload_len = '0; peer_window_adv = '0; app_action = '0;
        out_stall = 1'b0;
        m_rwin = 16'hFFFF; m_iss = 32'd0; m_state = ST_LISTEN;
        m_exp = 0; m_nss = 0; m_pwin = 0; m_lpa = 0; m_las = 0;
        for (int i = 0; i < DEPTH; i++)
        begin
            tab_v[i] = 1'b0; tab_seq[i] = 0; tab_len[i] = 0; tab_fin[i] = 1'b0;
        end
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        write_reg(CFG_INIT_SEQ, 32'd0);
        write_reg(CFG_INIT_SEQ, 32'hFFFF_FFFF);
        write_reg(CFG_RECV_WIN, 32'h0000_FFFF);
        test_listen();
        test_syn_received();
        test_established(100);
        drain();

        write_reg(CFG_RECV_WIN, 32'd0);
        gap_pct = 65;
        test_established(60);
        drain();

        write_reg(CFG_RECV_WIN, $urandom_range(1000, 65535));
        write_reg(CFG_INIT_SEQ, $urandom);
        gap_pct = 0;
        stall_pct = 65;
        hold_left = 400;
        test_established(100);
        drain();

        write_reg(CFG_RECV_WIN, 32'h0000_FFFF);
        gap_pct = 31;
        stall_pct = 31;
        test_established(100);
        test_close_down();
        drain();

        if (errors == 0 && pending_res.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

### sim.f
hw/rtl/trs_pkg.sv
hw/rtl/trs_ctrl.sv
hw/rtl/trs_dp.sv
hw/rtl/tcp_receive_session_fsm.sv
bench/tb.sv
